/* rtl/core/rpcz_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpcz_pkg
// shared types, widths and constants of the rolling pair correlation unit
// ----------------------------------------------------------------------------
package rpcz_pkg;

    localparam int unsigned MaxPairsDef    = 4096;
    localparam int unsigned MaxLookbackDef = 256;
    localparam int unsigned PriceBitsDef   = 24;

    localparam int unsigned LenW  = 9;
    localparam int unsigned PairW = 12;
    localparam int unsigned ThrW  = 16;
    localparam int unsigned CorrW = 16;
    localparam int unsigned SigW  = 2;
    localparam int unsigned ReqW  = 2;

    localparam logic [ReqW-1:0] REQ_START = 2'd0;
    localparam logic [ReqW-1:0] REQ_ADD   = 2'd1;
    localparam logic [ReqW-1:0] REQ_SLIDE = 2'd2;
    localparam logic [ReqW-1:0] REQ_NONE  = 2'd3;

    localparam logic [LenW-1:0] LEN_RESET = 9'd64;

    // datapath step commands
    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_CLEAR,
        CMD_READ,
        CMD_UPD,
        CMD_WRITE,
        CMD_VAR,
        CMD_SQRT,
        CMD_DEN,
        CMD_DIV,
        CMD_SIG,
        CMD_DONE
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_READ2,
        ST_UPD,
        ST_WRITE,
        ST_VAR,
        ST_SQRT,
        ST_DEN,
        ST_DIV,
        ST_SIG,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_cmd cmd;
        logic start_iter;
    } t_ctrl;

    typedef struct packed {
        logic iter_done;
        logic clear_done;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/core/rpcz_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpcz_ctrl
// sequencer for the clear sweep, update, square roots, divide and signal
// ----------------------------------------------------------------------------
module rpcz_ctrl
    import rpcz_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_start,
    input  wire   i_out_free,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_busy,
    output logic  o_ready
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (i_stat.clear_done) n_state = ST_IDLE;
            ST_IDLE:  if (i_start) n_state = ST_READ;
            ST_READ:  n_state = ST_READ2;
            ST_READ2: n_state = ST_UPD;
            ST_UPD:   n_state = ST_WRITE;
            ST_WRITE: n_state = ST_VAR;
            ST_VAR:   n_state = ST_SQRT;
            ST_SQRT:  if (i_stat.iter_done) n_state = ST_DEN;
            ST_DEN:   n_state = ST_DIV;
            ST_DIV:   if (i_stat.iter_done) n_state = ST_SIG;
            ST_SIG:   if (i_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl.cmd        = CMD_IDLE;
        o_ctrl.start_iter = 1'b0;
        o_busy            = 1'b1;
        o_ready           = 1'b0;
        case (r_state)
            ST_CLEAR: o_ctrl.cmd = CMD_CLEAR;
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_ready    = 1'b1;
                o_ctrl.cmd = CMD_LOAD;
            end
            ST_READ:  o_ctrl.cmd = CMD_READ;
            ST_READ2: o_ctrl.cmd = CMD_IDLE;
            ST_UPD:   o_ctrl.cmd = CMD_UPD;
            ST_WRITE: o_ctrl.cmd = CMD_WRITE;
            ST_VAR: begin
                o_ctrl.cmd        = CMD_VAR;
                o_ctrl.start_iter = 1'b1;
            end
            ST_SQRT:  o_ctrl.cmd = CMD_SQRT;
            ST_DEN: begin
                o_ctrl.cmd        = CMD_DEN;
                o_ctrl.start_iter = 1'b1;
            end
            ST_DIV:   o_ctrl.cmd = CMD_DIV;
            ST_SIG: begin
                if (i_out_free) o_ctrl.cmd = CMD_SIG;
            end
            default:  o_ctrl.cmd = CMD_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/rpcz_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpcz_dp
// per-pair sum store, variance terms, bit-serial roots and divider
// ----------------------------------------------------------------------------
module rpcz_dp
    import rpcz_pkg::*;
#(
    parameter int unsigned MAX_PAIRS    = MaxPairsDef,
    parameter int unsigned MAX_LOOKBACK = MaxLookbackDef,
    parameter int unsigned PRICE_BITS   = PriceBitsDef
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  t_ctrl                       i_ctrl,
    input  wire                         i_load,
    input  wire        [LenW-1:0]       i_len,
    input  wire        [ReqW-1:0]       i_req,
    input  wire        [PairW-1:0]      i_pair,
    input  wire signed [PRICE_BITS-1:0] i_an,
    input  wire signed [PRICE_BITS-1:0] i_bn,
    input  wire signed [PRICE_BITS-1:0] i_ao,
    input  wire signed [PRICE_BITS-1:0] i_bo,
    input  wire        [ThrW-1:0]       i_thr,
    output t_stat                       o_stat,
    output logic       [PairW-1:0]      o_pair,
    output logic signed [CorrW-1:0]     o_corr,
    output logic signed [SigW-1:0]      o_sig
);

    localparam int unsigned AW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int unsigned NW   = $clog2(MAX_LOOKBACK + 1);
    localparam int unsigned WS   = PRICE_BITS + 8;
    localparam int unsigned WQ   = 2 * PRICE_BITS + 8;
    localparam int unsigned WX   = 2 * PRICE_BITS + 9;
    localparam int unsigned WSS  = PRICE_BITS + 9;
    localparam int unsigned WSQ  = 2 * PRICE_BITS + 10;
    localparam int unsigned RW   = WS + WQ + WQ + WX + WSS + WSQ + WS;
    localparam int unsigned VW   = WSQ + NW + 2;
    localparam int unsigned SRW  = VW / 2 + 1;
    localparam int unsigned DENW = 2 * SRW;
    localparam int unsigned NUMW = VW + 15;
    localparam int unsigned CW   = $clog2(NUMW + 1);
    localparam int unsigned DW   = WSS + NW + 2;
    localparam int unsigned LW   = 2 * DW + 16;
    localparam int unsigned HW   = VW + 2 * ThrW;
    localparam int unsigned MW   = (LW > HW) ? LW : HW;

    logic [RW-1:0]   r_mem [MAX_PAIRS];
    logic [RW-1:0]   r_rd;
    logic [AW-1:0]   r_clr_addr;
    logic [AW-1:0]   r_addr;
    logic [ReqW-1:0] r_req;
    logic [PairW-1:0] r_pair;
    logic [PairW-1:0] r_opair;
    logic signed [PRICE_BITS-1:0] r_an, r_bn, r_ao, r_bo;
    logic [ThrW-1:0] r_thr;
    logic [NW-1:0]   r_n;

    logic signed [WS-1:0]  r_sa, r_sb;
    logic signed [WQ-1:0]  r_saa, r_sbb;
    logic signed [WX-1:0]  r_sab;
    logic signed [WSS-1:0] r_ss;
    logic signed [WSQ-1:0] r_ssq;

    logic signed [VW-1:0] r_va, r_vb, r_cv, r_vs;
    logic signed [DW-1:0] r_d;

    logic [VW-1:0]   r_xa, r_xb, r_ra, r_rb, r_bit;
    logic [NUMW-1:0] r_num, r_q;
    logic [NUMW:0]   r_rem;
    logic [DENW-1:0] r_den;
    logic [CW-1:0]   r_cnt;
    logic            r_cneg, r_vok;

    logic [MW-1:0]     r_mla, r_mra, r_lhs, r_rhs;
    logic [DW-1:0]     r_mlb;
    logic [2*ThrW-1:0] r_mrb;

    logic signed [SigW-1:0] r_sig;
    logic signed [CorrW-1:0] r_corr;

    logic w_clear_done, w_iter_done;

    wire [NW-1:0] w_n_cl = (i_len == '0) ? NW'(1)
                         : ((32'(i_len) > MAX_LOOKBACK) ? NW'(MAX_LOOKBACK) : NW'(i_len));

    // ---- clear sweep and store ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_ctrl.cmd == CMD_CLEAR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end
    assign w_clear_done = (32'(r_clr_addr) == MAX_PAIRS - 1);
    assign w_iter_done  = (r_cnt == CW'(1));
    assign o_stat       = '{iter_done: w_iter_done, clear_done: w_clear_done};

    logic [RW-1:0] w_wr;
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmd == CMD_CLEAR) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_ctrl.cmd == CMD_WRITE) begin
            r_mem[r_addr] <= w_wr;
        end
        r_rd <= r_mem[r_addr];
    end
    assign w_wr = {r_ssq, r_ss, r_sab, r_sbb, r_saa, r_sb, r_sa};

    // ---- update terms ----
    logic signed [2*PRICE_BITS-1:0] w_aa_n, w_bb_n, w_ab_n, w_aa_o, w_bb_o, w_ab_o;
    logic signed [2*PRICE_BITS+1:0] w_s2n, w_s2o;
    logic signed [PRICE_BITS:0] w_sn, w_so;
    logic w_sub;
    always_comb begin
        w_sn   = (PRICE_BITS+1)'(r_an) - (PRICE_BITS+1)'(r_bn);
        w_so   = (PRICE_BITS+1)'(r_ao) - (PRICE_BITS+1)'(r_bo);
        w_aa_n = r_an * r_an;
        w_bb_n = r_bn * r_bn;
        w_ab_n = r_an * r_bn;
        w_aa_o = r_ao * r_ao;
        w_bb_o = r_bo * r_bo;
        w_ab_o = r_ao * r_bo;
        w_s2n  = w_sn * w_sn;
        w_s2o  = w_so * w_so;
        w_sub  = (r_req == REQ_SLIDE);
    end

    // ---- root and divide helpers ----
    logic [VW-1:0] w_ta, w_tb;
    assign w_ta = r_ra + r_bit;
    assign w_tb = r_rb + r_bit;
    logic [NUMW:0] w_rs;
    assign w_rs = {r_rem[NUMW-1:0], r_num[NUMW-1]};

    logic [DW-1:0] w_dmag;
    assign w_dmag = r_d[DW-1] ? -r_d : r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.start_iter) begin
            r_cnt <= (i_ctrl.cmd == CMD_VAR) ? CW'(SRW) : CW'(NUMW);
        end else if ((i_ctrl.cmd == CMD_SQRT || i_ctrl.cmd == CMD_DIV) && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // update, variance terms, two root lanes, divide and shift-add signal products
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_req  <= i_req;
            r_pair <= i_pair;
            r_addr <= AW'(i_pair % MAX_PAIRS);
            r_an <= i_an; r_bn <= i_bn; r_ao <= i_ao; r_bo <= i_bo;
            r_thr <= i_thr;
            r_n   <= w_n_cl;
        end
        case (i_ctrl.cmd)
            CMD_UPD: begin
                if (r_req == REQ_NONE) begin
                    {r_ssq, r_ss, r_sab, r_sbb, r_saa, r_sb, r_sa} <= r_rd;
                end else begin
                    r_sa  <= (r_req == REQ_START ? WS'(0) : r_rd[WS-1:0])
                           + WS'(r_an) - (w_sub ? WS'(r_ao) : WS'(0));
                    r_sb  <= (r_req == REQ_START ? WS'(0) : r_rd[2*WS-1 -: WS])
                           + WS'(r_bn) - (w_sub ? WS'(r_bo) : WS'(0));
                    r_saa <= (r_req == REQ_START ? WQ'(0) : r_rd[2*WS +: WQ])
                           + WQ'(w_aa_n) - (w_sub ? WQ'(w_aa_o) : WQ'(0));
                    r_sbb <= (r_req == REQ_START ? WQ'(0) : r_rd[2*WS+WQ +: WQ])
                           + WQ'(w_bb_n) - (w_sub ? WQ'(w_bb_o) : WQ'(0));
                    r_sab <= (r_req == REQ_START ? WX'(0) : r_rd[2*WS+2*WQ +: WX])
                           + WX'(w_ab_n) - (w_sub ? WX'(w_ab_o) : WX'(0));
                    r_ss  <= (r_req == REQ_START ? WSS'(0) : r_rd[2*WS+2*WQ+WX +: WSS])
                           + WSS'(w_sn) - (w_sub ? WSS'(w_so) : WSS'(0));
                    r_ssq <= (r_req == REQ_START ? WSQ'(0)
                                                 : r_rd[2*WS+2*WQ+WX+WSS +: WSQ])
                           + WSQ'(w_s2n) - (w_sub ? WSQ'(w_s2o) : WSQ'(0));
                end
            end
            CMD_VAR: begin
                r_va  <= VW'(r_n) * VW'(r_saa) - VW'(r_sa) * VW'(r_sa);
                r_vb  <= VW'(r_n) * VW'(r_sbb) - VW'(r_sb) * VW'(r_sb);
                r_cv  <= VW'(r_n) * VW'(r_sab) - VW'(r_sa) * VW'(r_sb);
                r_vs  <= VW'(r_n) * VW'(r_ssq) - VW'(r_ss) * VW'(r_ss);
                r_d   <= DW'(r_n) * DW'(w_sn) - DW'(r_ss);
                r_xa  <= VW'(r_n) * VW'(r_saa) - VW'(r_sa) * VW'(r_sa);
                r_xb  <= VW'(r_n) * VW'(r_sbb) - VW'(r_sb) * VW'(r_sb);
                r_ra  <= '0;
                r_rb  <= '0;
                r_bit <= VW'(1) << (2 * (SRW - 1));
            end
            CMD_SQRT: begin
                if (r_xa >= w_ta) begin
                    r_xa <= r_xa - w_ta;
                    r_ra <= (r_ra >> 1) + r_bit;
                end else begin
                    r_ra <= r_ra >> 1;
                end
                if (r_xb >= w_tb) begin
                    r_xb <= r_xb - w_tb;
                    r_rb <= (r_rb >> 1) + r_bit;
                end else begin
                    r_rb <= r_rb >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            CMD_DEN: begin
                r_den  <= DENW'(r_ra[SRW-1:0]) * DENW'(r_rb[SRW-1:0]);
                r_rem  <= '0;
                r_q    <= '0;
                r_cneg <= r_cv[VW-1];
                r_num  <= NUMW'(r_cv[VW-1] ? -r_cv : r_cv) << 15;
                r_vok  <= !r_va[VW-1] && (r_va != '0) && !r_vb[VW-1] && (r_vb != '0);
                r_mla  <= MW'(w_dmag) << 16;
                r_mlb  <= w_dmag;
                r_mra  <= MW'($unsigned(r_vs));
                r_mrb  <= (2*ThrW)'(r_thr) * (2*ThrW)'(r_thr);
                r_lhs  <= '0;
                r_rhs  <= '0;
            end
            CMD_DIV: begin
                if (w_rs >= (NUMW+1)'(r_den)) begin
                    r_rem <= w_rs - (NUMW+1)'(r_den);
                    r_q   <= {r_q[NUMW-2:0], 1'b1};
                end else begin
                    r_rem <= w_rs;
                    r_q   <= {r_q[NUMW-2:0], 1'b0};
                end
                r_num <= r_num << 1;
                if (r_mlb[0]) r_lhs <= r_lhs + r_mla;
                r_mla <= r_mla << 1;
                r_mlb <= r_mlb >> 1;
                if (r_mrb[0]) r_rhs <= r_rhs + r_mra;
                r_mra <= r_mra << 1;
                r_mrb <= r_mrb >> 1;
            end
            CMD_SIG: begin
                r_opair <= r_pair;
                if (!r_vok) begin
                    r_corr <= '0;
                end else if (r_cneg) begin
                    r_corr <= (r_q > NUMW'(32768)) ? -16'sd32768 : CorrW'(-r_q);
                end else begin
                    r_corr <= (r_q > NUMW'(32767)) ? 16'sd32767 : CorrW'(r_q);
                end
                if (!r_vs[VW-1] && r_vs != '0 && r_d != '0 && r_lhs > r_rhs) begin
                    r_sig <= r_d[DW-1] ? -2'sd1 : 2'sd1;
                end else begin
                    r_sig <= '0;
                end
            end
            default: ;
        endcase
    end

    assign o_pair = r_opair;
    assign o_corr = r_corr;
    assign o_sig  = r_sig;

    property p_iter_bounded;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_ctrl.cmd == CMD_VAR) |=> (r_cnt == CW'(SRW));
    endproperty
    a_iter_bounded: assert property (p_iter_bounded) else $error("root count not loaded");

    a_clear_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.cmd == CMD_CLEAR && o_stat.clear_done) |=> (r_clr_addr == '0))
        else $error("clear sweep did not wrap");

    a_sig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.cmd == CMD_SIG) |=> (r_sig != 2'b10))
        else $error("signal out of range");

endmodule
`default_nettype wire

/* rtl/core/rolling_pair_correlation_zscore_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_pair_correlation_zscore_unit
// windowed pair correlation and spread z-score signal per symbol pair
// ----------------------------------------------------------------------------
// flow: each word passes the sum update, the bit-serial root lanes and the divider;
// the next word is accepted only once the previous result is registered; the pace is set
// by the root lanes and the divider, a held result stalls only the final step
// reset: synchronous active low; a clearing pass over all MAX_PAIRS entries zeroes
// the sum store, no word is accepted during it; lookback resets to 64
module rolling_pair_correlation_zscore_unit
    import rpcz_pkg::*;
#(
    parameter int unsigned MAX_PAIRS    = MaxPairsDef,
    parameter int unsigned MAX_LOOKBACK = MaxLookbackDef,
    parameter int unsigned PRICE_BITS   = PriceBitsDef
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [LenW-1:0]      i_cfg_data,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // pair_index, price_a_new, price_b_new, price_a_old, price_b_old, z_threshold
    input  wire  [PairW+4*PRICE_BITS+ThrW+3:0] s_axis_tdata,
    // req_type
    input  wire  [ReqW-1:0]      s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // result_pair, correlation, trade_signal, zero fill
    output logic [31:0]          m_axis_tdata
);

    localparam int unsigned P = PRICE_BITS;

    logic [LenW-1:0] r_len;
    logic            r_ovalid;
    t_ctrl           w_ctrl;
    t_stat           w_stat;
    logic            w_busy, w_ready;
    logic [PairW-1:0] w_pair;
    logic signed [CorrW-1:0] w_corr;
    logic signed [SigW-1:0] w_sig;
    wire w_acc  = s_axis_tvalid && s_axis_tready;
    wire w_done = (w_ctrl.cmd == CMD_SIG);

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_valid) begin
            r_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign s_axis_tready = w_ready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, w_sig, w_corr, w_pair};

    rpcz_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_acc),
        .i_out_free(!r_ovalid || m_axis_tready),
        .i_stat    (w_stat),
        .o_ctrl    (w_ctrl),
        .o_busy    (w_busy),
        .o_ready   (w_ready)
    );

    rpcz_dp #(
        .MAX_PAIRS   (MAX_PAIRS),
        .MAX_LOOKBACK(MAX_LOOKBACK),
        .PRICE_BITS  (PRICE_BITS)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_ctrl),
        .i_load (w_acc),
        .i_len  (r_len),
        .i_req  (s_axis_tuser),
        .i_pair (s_axis_tdata[PairW-1:0]),
        .i_an   (s_axis_tdata[PairW +: P]),
        .i_bn   (s_axis_tdata[PairW+P +: P]),
        .i_ao   (s_axis_tdata[PairW+2*P +: P]),
        .i_bo   (s_axis_tdata[PairW+3*P +: P]),
        .i_thr  (s_axis_tdata[PairW+4*P +: ThrW]),
        .o_stat (w_stat),
        .o_pair (w_pair),
        .o_corr (w_corr),
        .o_sig  (w_sig)
    );

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_busy) else $error("ready while busy");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !r_ovalid || m_axis_tready) else $error("result overwritten");
    a_no_accept_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> !w_done) else $error("accept during finish");

endmodule
`default_nettype wire

/* tb/sv/rpcz_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcz_checker
// watches the config, input and result channels of the correlation unit,
// keeps its own per-pair window sums, predicts correlation and trade signal
// for each accepted word and compares them with the results in order
// ----------------------------------------------------------------------------
module rpcz_checker
    import rpcz_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_valid,
    input  wire          i_cfg_ready,
    input  wire [LenW-1:0] i_cfg_data,
    input  wire          i_s_valid,
    input  wire          i_s_ready,
    input  wire [127:0]  i_s_data,
    input  wire [ReqW-1:0] i_s_user,
    input  wire          i_m_valid,
    input  wire          i_m_ready,
    input  wire [31:0]   i_m_data,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [PairW-1:0] pair;
        logic [CorrW-1:0] corr;
        logic [SigW-1:0]  sig;
    } t_result;

    logic [31:0] sum_a   [MaxPairsDef];
    logic [31:0] sum_b   [MaxPairsDef];
    logic [55:0] sum_aa  [MaxPairsDef];
    logic [55:0] sum_bb  [MaxPairsDef];
    logic [56:0] sum_ab  [MaxPairsDef];
    logic [32:0] sum_s   [MaxPairsDef];
    logic [57:0] sum_ss  [MaxPairsDef];
    logic [LenW-1:0] window_len;
    t_result expected_results [$];

    initial begin
        for (int i = 0; i < MaxPairsDef; i++) begin
            sum_a[i] = '0; sum_b[i] = '0; sum_aa[i] = '0; sum_bb[i] = '0;
            sum_ab[i] = '0; sum_s[i] = '0; sum_ss[i] = '0;
        end
        o_fail_count = 0;
        window_len = LEN_RESET;
    end

    assign o_pending = expected_results.size();

    function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
        logic [127:0] res;
        logic [127:0] bitv;
        logic [127:0] t;
        res = '0;
        bitv = 128'd1 << 126;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            t = res + bitv;
            if (x >= t) begin
                x = x - t;
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // updates the pair sums and returns the predicted result
    function automatic t_result update_and_predict(input logic [ReqW-1:0] req,
                                                   input logic [127:0] d);
        logic [PairW-1:0] p;
        logic signed [127:0] an, bn, ao, bo, sn, so, nn;
        logic signed [127:0] sa, sb, saa, sbb, sab, ss, sss;
        logic signed [127:0] va, vb, cv, v, dd;
        logic [127:0] num, den, q, ud, lhs, rhs, thr;
        logic slide;
        t_result r;
        p  = d[11:0];
        an = $signed(d[35:12]);
        bn = $signed(d[59:36]);
        ao = $signed(d[83:60]);
        bo = $signed(d[107:84]);
        thr = {112'd0, d[123:108]};
        sn = an - bn;
        so = ao - bo;
        nn = (window_len == 0) ? 1 : (window_len > MaxLookbackDef) ? MaxLookbackDef
             : {119'd0, window_len};
        slide = (req == REQ_SLIDE);
        if (req == REQ_START) begin
            sum_a[p] = '0; sum_b[p] = '0; sum_aa[p] = '0; sum_bb[p] = '0;
            sum_ab[p] = '0; sum_s[p] = '0; sum_ss[p] = '0;
        end
        if (req != REQ_NONE) begin
            if (!slide) begin
                ao = 0; bo = 0; so = 0;
            end
            sum_a[p]  = 32'($signed(sum_a[p]) + an - ao);
            sum_b[p]  = 32'($signed(sum_b[p]) + bn - bo);
            sum_aa[p] = 56'($signed(sum_aa[p]) + an * an - ao * ao);
            sum_bb[p] = 56'($signed(sum_bb[p]) + bn * bn - bo * bo);
            sum_ab[p] = 57'($signed(sum_ab[p]) + an * bn - ao * bo);
            sum_s[p]  = 33'($signed(sum_s[p]) + sn - so);
            sum_ss[p] = 58'($signed(sum_ss[p]) + sn * sn - so * so);
        end
        sa  = $signed(sum_a[p]);
        sb  = $signed(sum_b[p]);
        saa = $signed(sum_aa[p]);
        sbb = $signed(sum_bb[p]);
        sab = $signed(sum_ab[p]);
        ss  = $signed(sum_s[p]);
        sss = $signed(sum_ss[p]);
        va = nn * saa - sa * sa;
        vb = nn * sbb - sb * sb;
        cv = nn * sab - sa * sb;
        r.pair = p;
        r.corr = '0;
        r.sig  = '0;
        if (va > 0 && vb > 0) begin
            den = floor_sqrt(va) * floor_sqrt(vb);
            num = (cv < 0 ? -cv : cv) << 15;
            q = num / den;
            if (cv < 0) r.corr = (q > 32768) ? 16'h8000 : 16'(-q);
            else        r.corr = (q > 32767) ? 16'h7fff : 16'(q);
        end
        v  = nn * sss - ss * ss;
        dd = nn * sn - ss;
        if (v > 0 && dd != 0) begin
            ud  = dd < 0 ? -dd : dd;
            lhs = (ud * ud) << 16;
            rhs = v * (thr * thr);
            if (lhs > rhs) r.sig = dd > 0 ? 2'b01 : 2'b11;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            window_len <= LEN_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_ready) window_len <= i_cfg_data;
            if (i_s_valid && i_s_ready)
                expected_results.push_back(update_and_predict(i_s_user, i_s_data));
            if (i_m_valid && i_m_ready) begin
                got = {i_m_data[11:0], i_m_data[27:12], i_m_data[29:28]};
                if (expected_results.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result word: pair %0d corr %0d sig %0d",
                                 got.pair, $signed(got.corr), $signed(got.sig));
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: exp pair %0d corr %0d sig %0d, got pair %0d corr %0d sig %0d",
                                     want.pair, $signed(want.corr), $signed(want.sig),
                                     got.pair, $signed(got.corr), $signed(got.sig));
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/rolling_pair_correlation_zscore_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_pair_correlation_zscore_unit_test
// drives directed and random pair updates through several window lengths,
// with random gaps and back pressure; the checker does the comparison
// ----------------------------------------------------------------------------
module rolling_pair_correlation_zscore_unit_test;
    import rpcz_pkg::*;

    localparam int PMAX = 8388607;
    localparam int PMIN = -8388608;
    localparam int CycleLimit = 3000000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [LenW-1:0] i_cfg_data = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata = '0;
    logic [ReqW-1:0] s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [31:0]   m_axis_tdata;
    int            fail_count;
    int            pending_results;
    int            cycle_count = 0;
    int            stall_left = 0;
    int            win_a [8][$];
    int            win_b [8][$];
    logic [PairW-1:0] slot_pair [8];

    rolling_pair_correlation_zscore_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    rpcz_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready),
        .i_s_data(s_axis_tdata), .i_s_user(s_axis_tuser),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready), .i_m_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending_results)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side back pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (cycle_count % 4000 < 1500 || $urandom_range(0, 99) < 60) begin
            m_axis_tready <= 1'b1;
        end else begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                          : $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
    end

    task automatic send_word(input logic [ReqW-1:0] req, input logic [PairW-1:0] pair,
                             input int an, input int bn, input int ao, input int bo,
                             input logic [ThrW-1:0] thr);
        int gap;
        gap = (cycle_count % 5000 < 1200) ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tuser <= req;
        s_axis_tdata <= {4'd0, thr, 24'(bo), 24'(ao), 24'(bn), 24'(an), pair};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_lookback(input logic [LenW-1:0] len);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        i_cfg_data <= len;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        for (int k = 0; k < 8; k++) begin
            win_a[k].delete();
            win_b[k].delete();
            slot_pair[k] = 12'($urandom_range(0, 4095));
        end
    endtask

    function automatic int rand_price();
        return int'($signed(24'($urandom())));
    endfunction

    task automatic random_word(input int eff_len);
        int slot, a, b, ao, bo, r;
        logic [ThrW-1:0] thr;
        r = $urandom_range(0, 99);
        thr = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 800));
        if (r < 8) begin
            send_word(2'($urandom()), 12'($urandom()), rand_price(), rand_price(),
                      rand_price(), rand_price(), thr);
            return;
        end
        slot = $urandom_range(0, 7);
        if (r < 20) begin
            a = rand_price();
            b = rand_price();
        end else begin
            a = $urandom_range(0, 2000000) - 1000000;
            b = (slot[0] ? a / 2 : -a) + $urandom_range(0, 20000) - 10000;
        end
        if (win_a[slot].size() == 0) begin
            send_word(REQ_START, slot_pair[slot], a, b, 0, 0, thr);
        end else if (win_a[slot].size() < eff_len) begin
            send_word(REQ_ADD, slot_pair[slot], a, b, rand_price(), rand_price(), thr);
        end else begin
            ao = win_a[slot].pop_front();
            bo = win_b[slot].pop_front();
            send_word(REQ_SLIDE, slot_pair[slot], a, b, ao, bo, thr);
        end
        win_a[slot].push_back(a);
        win_b[slot].push_back(b);
    endtask

    initial begin
        logic [LenW-1:0] lens [7];
        int eff;
        lens = '{9'd3, 9'd1, 9'd256, 9'd0, 9'd511, 9'd17, 9'd64};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_lookback(9'd4);

        // directed words
        send_word(REQ_START, 12'd0, PMAX, PMAX, 0, 0, 16'd0);
        send_word(REQ_ADD,   12'd0, PMIN, PMIN, 0, 0, 16'd0);
        send_word(REQ_ADD,   12'd0, PMAX, PMIN, 0, 0, 16'hffff);
        send_word(REQ_ADD,   12'd0, 0, PMAX, 0, 0, 16'd256);
        send_word(REQ_SLIDE, 12'd0, PMIN, PMAX, PMAX, PMAX, 16'd128);
        send_word(REQ_SLIDE, 12'd0, PMIN, PMIN, PMIN, PMAX, 16'd0);
        send_word(REQ_NONE,  12'd0, PMAX, PMIN, PMIN, PMAX, 16'd0);
        send_word(REQ_START, 12'd4095, 4096, 4096, 0, 0, 16'd0);
        send_word(REQ_ADD,   12'd4095, 4096, 4096, 0, 0, 16'd0);
        send_word(REQ_ADD,   12'd4095, 8192, 8192, 0, 0, 16'd0);
        send_word(REQ_ADD,   12'd4095, -8192, 8192, 0, 0, 16'd1);
        send_word(REQ_SLIDE, 12'd4095, 100, -100, 4096, 4096, 16'd300);
        send_word(REQ_START, 12'd7, 1000, 2000, 0, 0, 16'd0);
        send_word(REQ_ADD,   12'd7, 1000, 2000, 0, 0, 16'd0);
        send_word(REQ_NONE,  12'd4000, 5, 6, 7, 8, 16'd10);
        send_word(REQ_SLIDE, 12'd100, 1, 2, 3, 4, 16'd5);
        send_word(REQ_ADD,   12'd2048, PMIN, PMAX, 0, 0, 16'hffff);

        foreach (lens[i]) begin
            write_lookback(lens[i]);
            eff = (lens[i] == 0) ? 1 : (lens[i] > MaxLookbackDef) ? MaxLookbackDef : lens[i];
            repeat (112) random_word(eff);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/rpcz_pkg.sv
rtl/core/rpcz_ctrl.sv
rtl/core/rpcz_dp.sv
rtl/core/rolling_pair_correlation_zscore_unit.sv
tb/sv/rpcz_checker.sv
tb/sv/rolling_pair_correlation_zscore_unit_test.sv
